// ----- design/okvt_pkg.sv -----
// Shared types and constants for the ordered key-value table.
// No dependencies; imported by okvt_cell and ordered_key_value_table.
`default_nettype none

package okvt_pkg;

   localparam int ENTRIES     = 16;
   localparam int KEY_WIDTH   = 32;
   localparam int VALUE_WIDTH = 32;

   typedef enum logic [1:0] {
      CMD_DEFINE = 2'd0,
      CMD_LOOKUP = 2'd1,
      CMD_ERASE  = 2'd2
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_NOT_FOUND = 2'd1,
      ST_FULL      = 2'd2
   } status_type;

   // Command broadcast to every cell
   typedef struct packed {
      logic                   go;
      logic [1:0]             command;
      logic [KEY_WIDTH-1:0]   key;
      logic [VALUE_WIDTH-1:0] value;
   } cmd_bus_type;

   // Passed from an older cell to the next younger one
   typedef struct packed {
      logic                   seen_hit;
      logic                   valid;
      logic [VALUE_WIDTH-1:0] pick;
   } older_link_type;

   // Passed from a younger cell to the next older one, for closing gaps
   typedef struct packed {
      logic                   valid;
      logic [KEY_WIDTH-1:0]   key;
      logic [VALUE_WIDTH-1:0] value;
   } shift_link_type;

endpackage : okvt_pkg

`default_nettype wire

// ----- design/okvt_cell.sv -----
// One table slot: holds a key, a value and a valid bit.
// Depends on okvt_pkg for the command and link structs.
`default_nettype none

module okvt_cell (
   input  wire                           clock,
   input  wire                           reset,
   input  okvt_pkg::cmd_bus_type         cmd,
   input  okvt_pkg::older_link_type      older_i,
   output okvt_pkg::older_link_type      younger_o,
   input  okvt_pkg::shift_link_type      behind_i,
   output okvt_pkg::shift_link_type      ahead_o
);
   import okvt_pkg::*;

   logic                   valid_ff, valid_in;
   logic [KEY_WIDTH-1:0]   key_ff, key_in;
   logic [VALUE_WIDTH-1:0] value_ff, value_in;
   logic                   hit;
   logic                   first_hit;
   logic                   do_load;
   logic                   do_shift;

   assign hit       = valid_ff && (key_ff == cmd.key);
   assign first_hit = hit && !older_i.seen_hit;

   // first empty slot behind a full one takes a new pair
   assign do_load  = cmd.go && (cmd.command == CMD_DEFINE) && !valid_ff && older_i.valid;
   // at or past the oldest match, take the younger neighbour's content
   assign do_shift = cmd.go && (cmd.command == CMD_ERASE) && (older_i.seen_hit || hit);

   always_comb begin
      valid_in = valid_ff;
      key_in   = key_ff;
      value_in = value_ff;
      if (do_load) begin
         valid_in = 1'b1;
         key_in   = cmd.key;
         value_in = cmd.value;
      end else if (do_shift) begin
         valid_in = behind_i.valid;
         key_in   = behind_i.key;
         value_in = behind_i.value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff   <= key_in;
      value_ff <= value_in;
   end

   assign younger_o.seen_hit = older_i.seen_hit || hit;
   assign younger_o.valid    = valid_ff;
   assign younger_o.pick     = older_i.pick | (first_hit ? value_ff : '0);

   assign ahead_o.valid = valid_ff;
   assign ahead_o.key   = key_ff;
   assign ahead_o.value = value_ff;

endmodule : okvt_cell

`default_nettype wire

// ----- design/ordered_key_value_table.sv -----
// Top level of the ordered key-value table: a row of okvt_cell slots
// plus the result register. Depends on okvt_pkg and okvt_cell.
`default_nettype none

// Ordered key-value table.
// Request channel (req_): tuser carries the command (define, lookup,
// erase), tdata carries key and value. Each accepted item yields exactly
// one item on the response channel (rsp_): tuser carries status and
// found, tdata carries the looked-up value.
// Entries sit in a row of cells, oldest in cell 0. Every cell compares
// its key with the request at once; a match flag and a value pick ripple
// from cell to cell, so the oldest match wins. Define fills the first
// empty cell; erase makes every cell at or after the oldest match take
// its younger neighbour's content, closing the gap in a single row update.
// A response item lands in the output register in the cycle after
// acceptance. Throughput: one item per cycle while the receiver keeps
// up; the row and the output register are the only stages.
// Reset clears every valid bit (empty table) and the output valid flag.
// When the receiver stalls, the response item holds in the output
// register and req_tready drops until it is taken; a taken response
// frees the register in the same cycle for the next item.
module ordered_key_value_table (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [1:0]  req_tuser,   // [1:0] command
   input  wire  [63:0] req_tdata,   // [31:0] key, [63:32] value
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [2:0]  rsp_tuser,   // [1:0] status, [2] found
   output logic [31:0] rsp_tdata    // [31:0] value_out
);
   import okvt_pkg::*;

   cmd_bus_type                 cmd;
   older_link_type              older_link [ENTRIES+1];
   shift_link_type              shift_link [ENTRIES+1];
   logic [ENTRIES-1:0]          valid_vec;
   logic                        go;
   logic                        full;

   logic                        rsp_valid_ff, rsp_valid_in;
   logic [1:0]                  status_ff, status_in;
   logic                        found_ff, found_in;
   logic [VALUE_WIDTH-1:0]      value_out_ff, value_out_in;

   // accept while the output register is empty or being drained
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign go         = req_tvalid && req_tready;

   assign cmd.go      = go;
   assign cmd.command = req_tuser;
   assign cmd.key     = req_tdata[KEY_WIDTH-1:0];
   assign cmd.value   = req_tdata[KEY_WIDTH +: VALUE_WIDTH];

   // head of the row: nothing older, treat as full so cell 0 may load
   assign older_link[0].seen_hit = 1'b0;
   assign older_link[0].valid    = 1'b1;
   assign older_link[0].pick     = '0;

   // tail of the row: shifting in from beyond the last cell empties it
   assign shift_link[ENTRIES].valid = 1'b0;
   assign shift_link[ENTRIES].key   = '0;
   assign shift_link[ENTRIES].value = '0;

   for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
      okvt_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .cmd       (cmd),
         .older_i   (older_link[i]),
         .younger_o (older_link[i+1]),
         .behind_i  (shift_link[i+1]),
         .ahead_o   (shift_link[i])
      );
      assign valid_vec[i] = older_link[i+1].valid;
   end

   assign full = valid_vec[ENTRIES-1];

   // result for the item being accepted
   always_comb begin
      status_in    = ST_OK;
      found_in     = 1'b0;
      value_out_in = '0;
      case (req_tuser)
         CMD_DEFINE: begin
            if (full) begin
               status_in = ST_FULL;
            end
         end
         CMD_LOOKUP: begin
            if (older_link[ENTRIES].seen_hit) begin
               found_in     = 1'b1;
               value_out_in = older_link[ENTRIES].pick;
            end else begin
               status_in = ST_NOT_FOUND;
            end
         end
         CMD_ERASE: begin
            if (older_link[ENTRIES].seen_hit) begin
               found_in = 1'b1;
            end else begin
               status_in = ST_NOT_FOUND;
            end
         end
         default: begin
            // unused code: no operation, plain ok
            status_in = ST_OK;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (go) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // hold payload unless a new item lands
   always_ff @(posedge clock) begin
      if (go) begin
         status_ff    <= status_in;
         found_ff     <= found_in;
         value_out_ff <= value_out_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = {found_ff, status_ff};
   assign rsp_tdata  = value_out_ff;

   // occupied cells always form a run from cell 0
   a_valid_packed: assert property (@(posedge clock) disable iff (reset)
      $onehot({1'b0, valid_vec} + {{ENTRIES{1'b0}}, 1'b1}))
      else $error("table holds a gap");

   // a define on a table with room adds exactly one entry
   a_define_grows: assert property (@(posedge clock) disable iff (reset)
      (go && req_tuser == CMD_DEFINE && !full) |=>
      ($countones(valid_vec) == $past($countones(valid_vec)) + 1))
      else $error("define did not add one entry");

   // a successful erase removes exactly one entry
   a_erase_shrinks: assert property (@(posedge clock) disable iff (reset)
      (go && req_tuser == CMD_ERASE && older_link[ENTRIES].seen_hit) |=>
      ($countones(valid_vec) + 1 == $past($countones(valid_vec))))
      else $error("erase did not remove one entry");

   // a lookup leaves the occupancy alone
   a_lookup_keeps: assert property (@(posedge clock) disable iff (reset)
      (go && req_tuser == CMD_LOOKUP) |=> $stable(valid_vec))
      else $error("lookup changed the table");

   // found goes only with an ok status
   a_found_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && found_ff) |-> (status_ff == ST_OK))
      else $error("found with bad status");

endmodule : ordered_key_value_table

`default_nettype wire
